FILE: rtl/core/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int PRIO_W   = 8;
    localparam int CODE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int OP_W     = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_EMPTY  = 2'd2;
    localparam logic [OP_W-1:0] OP_FULL   = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [PRIO_W-1:0] new_priority;
        logic [CODE_W-1:0] new_code;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PRIO_W-1:0]   out_priority;
        logic [CODE_W-1:0]   out_code;
        logic [COUNT_W-1:0]  entry_count;
    } t_out_word;

    typedef struct packed {
        logic            load;
        logic            exec;
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic req_remove;
        logic empty;
        logic full;
    } t_stat;

endpackage

FILE: rtl/core/spq_ctrl.sv
module spq_ctrl
    import spq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy,
    output logic  o_done
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_done, n_done;

    always_comb begin
        n_state    = r_state;
        n_done     = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        o_cmd.op   = OP_INSERT;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_done     = 1'b1;
                n_state    = S_IDLE;
                if (i_stat.req_remove) begin
                    o_cmd.op = i_stat.empty ? OP_EMPTY : OP_REMOVE;
                end else begin
                    o_cmd.op = i_stat.full ? OP_FULL : OP_INSERT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

FILE: rtl/core/spq_datapath.sv
module spq_datapath
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_word  i_req,
    output t_stat     o_stat,
    output t_out_word o_result
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_in_word          r_req;
    t_out_word         r_out, n_out;
    logic [CW-1:0]     r_count, n_count;
    logic [PRIO_W-1:0] r_slot_p [CAPACITY];
    logic [CODE_W-1:0] r_slot_c [CAPACITY];
    logic [PRIO_W-1:0] ins_p    [CAPACITY];
    logic [CODE_W-1:0] ins_c    [CAPACITY];
    logic [PRIO_W-1:0] rem_p    [CAPACITY];
    logic [CODE_W-1:0] rem_c    [CAPACITY];
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] prev_lt;
    logic [CAPACITY-1:0] place;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_slot
            assign lt[g] = (CW'(g) < r_count) && (r_slot_p[g] <= r_req.new_priority);
            if (g == 0) begin : g_front
                assign prev_lt[g] = 1'b1;
                assign ins_p[g]   = lt[g] ? r_slot_p[g] : r_req.new_priority;
                assign ins_c[g]   = lt[g] ? r_slot_c[g] : r_req.new_code;
            end else begin : g_rest
                assign prev_lt[g] = lt[g-1];
                assign ins_p[g]   = lt[g] ? r_slot_p[g] :
                                    (place[g] ? r_req.new_priority : r_slot_p[g-1]);
                assign ins_c[g]   = lt[g] ? r_slot_c[g] :
                                    (place[g] ? r_req.new_code : r_slot_c[g-1]);
            end
            if (g == CAPACITY - 1) begin : g_back
                assign rem_p[g] = r_slot_p[g];
                assign rem_c[g] = r_slot_c[g];
            end else begin : g_mid
                assign rem_p[g] = r_slot_p[g+1];
                assign rem_c[g] = r_slot_c[g+1];
            end
        end
    endgenerate

    assign place = ~lt & prev_lt;

    assign o_stat.req_remove = (r_req.req_type == REQ_REMOVE);
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.full       = (r_count == CW'(CAPACITY));

    always_comb begin
        n_count            = r_count;
        n_out              = r_out;
        if (i_cmd.exec) begin
            n_out.status       = ST_DONE;
            n_out.out_priority = '0;
            n_out.out_code     = '0;
            case (i_cmd.op)
                OP_INSERT: n_count = r_count + CW'(1);
                OP_REMOVE: begin
                    n_count            = r_count - CW'(1);
                    n_out.out_priority = r_slot_p[0];
                    n_out.out_code     = r_slot_c[0];
                end
                OP_EMPTY:  n_out.status = ST_EMPTY;
                OP_FULL:   n_out.status = ST_FULL;
                default:   n_out.status = ST_DONE;
            endcase
            n_out.entry_count = COUNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        r_out <= n_out;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_cmd.exec && i_cmd.op == OP_INSERT) begin
                r_slot_p[i] <= ins_p[i];
                r_slot_c[i] <= ins_c[i];
            end else if (i_cmd.exec && i_cmd.op == OP_REMOVE) begin
                r_slot_p[i] <= rem_p[i];
                r_slot_c[i] <= rem_c[i];
            end
        end
    end

    assign o_result = r_out;

endmodule

FILE: rtl/core/sorted_priority_queue.sv
// Sorted priority queue of CAPACITY (priority, code) entries; the smallest priority
// leaves first and equal priorities leave in arrival order. A request is taken when
// start is high and busy is low, and occupies the block for two cycles: one to
// capture the word, one in which every slot compares against the new priority and
// shifts in parallel. The result word appears on o_result with o_done high for
// exactly one cycle, the cycle after the shift; it is not held, so the receiver must
// take it then and cannot stall the block. A new request may be taken in that same
// cycle, giving one request every two cycles. Reset empties the queue at once; slot
// contents are not cleared.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_req,
    output logic      busy,
    output logic      o_done,
    output t_out_word o_result
);

    t_cmd  cmd;
    t_stat stat;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    spq_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int DEPTH         = CAPACITY;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_word  i_req   = '0;
    logic      busy;
    logic      o_done;
    t_out_word o_result;

    t_in_word  pending_words[$];
    t_out_word expected_results[$];

    logic [PRIO_W-1:0]  model_prio[DEPTH];
    logic [CODE_W-1:0]  model_code[DEPTH];
    int                 model_count = 0;

    int idle_pct    = 0;
    int fail_count  = 0;
    int quiet_ticks = 0;

    sorted_priority_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_out_word apply_request(input t_in_word w);
        t_out_word r;
        int pos;
        int k;
        r = '0;
        r.status = ST_DONE;
        if (w.req_type == REQ_REMOVE) begin
            if (model_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.out_priority = model_prio[0];
                r.out_code     = model_code[0];
                for (k = 1; k < model_count; k++) begin
                    model_prio[k-1] = model_prio[k];
                    model_code[k-1] = model_code[k];
                end
                model_count--;
            end
        end else begin
            if (model_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < model_count && model_prio[pos] <= w.new_priority)
                    pos++;
                for (k = model_count; k > pos; k--) begin
                    model_prio[k] = model_prio[k-1];
                    model_code[k] = model_code[k-1];
                end
                model_prio[pos] = w.new_priority;
                model_code[pos] = w.new_code;
                model_count++;
            end
        end
        r.entry_count = model_count[COUNT_W-1:0];
        return r;
    endfunction

    // drive: hold the word while busy, advance on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else begin
            if (start && !busy)
                expected_results.push_back(apply_request(i_req));
            if (!start || !busy) begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    i_req <= pending_words.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: %h", o_result);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_result.status);
                        fail_count++;
                    end
                    if (o_result.out_priority !== want.out_priority) begin
                        $error("out_priority: expected %0d, got %0d",
                               want.out_priority, o_result.out_priority);
                        fail_count++;
                    end
                    if (o_result.out_code !== want.out_code) begin
                        $error("out_code: expected %0h, got %0h",
                               want.out_code, o_result.out_code);
                        fail_count++;
                    end
                    if (o_result.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, o_result.entry_count);
                        fail_count++;
                    end
                end
            end
            if ((start && !busy) || o_done) begin
                quiet_ticks = 0;
            end else begin
                quiet_ticks++;
                if (quiet_ticks >= STALL_LIMIT) begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic queue_word(input logic op, input int prio, input int code);
        t_in_word w;
        w.req_type     = op;
        w.new_priority = prio[PRIO_W-1:0];
        w.new_code     = code[CODE_W-1:0];
        pending_words.push_back(w);
    endtask

    task automatic queue_segment(inout int added);
        int   kind;
        int   len;
        int   mode;
        int   base;
        int   prio;
        int   n;
        logic op;
        kind = $urandom_range(0, 3);
        mode = $urandom_range(0, 2);
        base = $urandom_range(0, 252);
        len  = (kind < 2) ? $urandom_range(1, 20) : $urandom_range(10, 40);
        for (n = 0; n < len; n++) begin
            case (kind)
                0: op = REQ_INSERT;
                1: op = REQ_REMOVE;
                2: op = $urandom_range(0, 1) ? REQ_INSERT : REQ_REMOVE;
                default: op = ($urandom_range(0, 9) < 7) ? REQ_INSERT : REQ_REMOVE;
            endcase
            case (mode)
                0: prio = $urandom_range(0, 255);
                1: prio = base + $urandom_range(0, 3);
                default: begin
                    case ($urandom_range(0, 3))
                        0: prio = 0;
                        1: prio = 1;
                        2: prio = 254;
                        default: prio = 255;
                    endcase
                end
            endcase
            queue_word(op, prio, $urandom_range(0, 65535));
        end
        added += len;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_words.size() > 0 || start || expected_results.size() > 0);
    endtask

    initial begin
        int phase_pct[5];
        int ph;
        int added;
        phase_pct = '{0, 78, 37, 78, 0};

        // empty queue, fill with extremes and ties, overflow, partial drain
        queue_word(REQ_REMOVE, 0, 0);
        queue_word(REQ_INSERT, 255, 'hffff);
        queue_word(REQ_INSERT, 0, 'h0000);
        queue_word(REQ_INSERT, 128, 'haaaa);
        queue_word(REQ_INSERT, 128, 'h5555);
        queue_word(REQ_INSERT, 128, 'h1234);
        queue_word(REQ_INSERT, 0, 'hffff);
        queue_word(REQ_INSERT, 255, 'h0001);
        queue_word(REQ_INSERT, 7, 'h8000);
        queue_word(REQ_INSERT, 7, 'h0100);
        queue_word(REQ_INSERT, 200, 'h00ff);
        queue_word(REQ_INSERT, 1, 'hff00);
        queue_word(REQ_INSERT, 254, 'h0f0f);
        queue_word(REQ_INSERT, 2, 'hf0f0);
        queue_word(REQ_INSERT, 128, 'h3c3c);
        queue_word(REQ_INSERT, 3, 'hc3c3);
        queue_word(REQ_INSERT, 9, 'h7777);
        queue_word(REQ_INSERT, 0, 'habcd);
        queue_word(REQ_REMOVE, 0, 0);
        queue_word(REQ_REMOVE, 0, 0);
        queue_word(REQ_REMOVE, 0, 0);
        queue_word(REQ_REMOVE, 0, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        for (ph = 0; ph < 5; ph++) begin
            idle_pct = phase_pct[ph];
            added = 0;
            while (added < 285)
                queue_segment(added);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
